### sv/cst_pkg.sv
// cst_pkg: shared types, constants and the divider step for the contrast stretch block
// no dependencies; used by every module of the block

package cst_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int PROD_BITS  = 2 * PIXEL_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [PIXEL_BITS-1:0] LEVEL_TOP = '1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_KNEE_IN_LOW   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KNEE_OUT_LOW  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KNEE_IN_HIGH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KNEE_OUT_HIGH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LEVEL     = 3'd5;

    localparam logic [1:0] SEG_LOW  = 2'd0;
    localparam logic [1:0] SEG_MID  = 2'd1;
    localparam logic [1:0] SEG_HIGH = 2'd2;

    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS_PER_STAGE = PIXEL_BITS / DIV_STAGES;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_level;
        logic                  last_pixel;
    } t_in;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] stretched_level;
        logic [PIXEL_BITS-1:0] binary_level;
        logic [1:0]            segment_used;
        logic                  last_pixel_out;
    } t_out;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] knee_in_low;
        logic [PIXEL_BITS-1:0] knee_out_low;
        logic [PIXEL_BITS-1:0] knee_in_high;
        logic [PIXEL_BITS-1:0] knee_out_high;
        logic [PIXEL_BITS-1:0] binary_threshold;
        logic [PIXEL_BITS-1:0] max_level;
    } t_cfg;

    // segment chosen; result is base +/- floor(p / d), p = a * b (+ d - 1 when rounding up)
    typedef struct packed {
        logic [1:0]            seg;
        logic                  last;
        logic [PIXEL_BITS-1:0] base;
        logic                  sub;
        logic                  rnd;
        logic [PIXEL_BITS-1:0] a;
        logic [PIXEL_BITS-1:0] b;
        logic [PIXEL_BITS-1:0] d;
    } t_sel;

    typedef struct packed {
        logic [1:0]            seg;
        logic                  last;
        logic [PIXEL_BITS-1:0] base;
        logic                  sub;
        logic [PROD_BITS-1:0]  p;
        logic [PIXEL_BITS-1:0] d;
    } t_num;

    // rem holds the partial remainder, quo the unused dividend bits then the quotient
    typedef struct packed {
        logic [1:0]            seg;
        logic                  last;
        logic [PIXEL_BITS-1:0] base;
        logic                  sub;
        logic [PIXEL_BITS-1:0] rem;
        logic [PIXEL_BITS-1:0] quo;
        logic [PIXEL_BITS-1:0] d;
    } t_div;

    // one restoring division step
    function automatic t_div div_step(t_div x);
        t_div                y;
        logic [PIXEL_BITS:0] t;
        logic [PIXEL_BITS:0] diff;
        logic                ge;
        y    = x;
        t    = {x.rem, x.quo[PIXEL_BITS-1]};
        diff = t - {1'b0, x.d};
        ge   = (t >= {1'b0, x.d});
        y.rem = ge ? diff[PIXEL_BITS-1:0] : t[PIXEL_BITS-1:0];
        y.quo = {x.quo[PIXEL_BITS-2:0], ge};
        return y;
    endfunction

endpackage

### sv/cst_seg.sv
// cst_seg: first stage, picks the curve segment and sets up operands for the division
// depends on cst_pkg

module cst_seg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cst_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  cst_pkg::t_in      i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output cst_pkg::t_sel     o_sel
);

    logic                          r_vld;
    cst_pkg::t_sel                 r_sel;
    cst_pkg::t_sel                 n_sel;
    logic [cst_pkg::PIXEL_BITS-1:0] w_v;

    assign w_v     = i_item.pixel_level;
    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_sel   = r_sel;

    always_comb begin
        n_sel      = '0;
        n_sel.last = i_item.last_pixel;
        if (w_v < i_cfg.knee_in_low) begin
            n_sel.seg  = cst_pkg::SEG_LOW;
            n_sel.base = '0;
            n_sel.sub  = 1'b0;
            n_sel.rnd  = 1'b0;
            n_sel.a    = i_cfg.knee_out_low;
            n_sel.b    = w_v;
            n_sel.d    = i_cfg.knee_in_low;
        end else if (w_v <= i_cfg.knee_in_high) begin
            n_sel.seg  = cst_pkg::SEG_MID;
            n_sel.base = i_cfg.knee_out_high;
            n_sel.b    = i_cfg.knee_in_high - w_v;
            // zero-width middle segment: b is zero, unit divisor leaves the base, knee_out_high
            if (i_cfg.knee_in_high == i_cfg.knee_in_low) begin
                n_sel.d = {{(cst_pkg::PIXEL_BITS-1){1'b0}}, 1'b1};
            end else begin
                n_sel.d = i_cfg.knee_in_high - i_cfg.knee_in_low;
            end
            if (i_cfg.knee_out_high >= i_cfg.knee_out_low) begin
                n_sel.a   = i_cfg.knee_out_high - i_cfg.knee_out_low;
                n_sel.sub = 1'b1;
                n_sel.rnd = 1'b1;
            end else begin
                n_sel.a   = i_cfg.knee_out_low - i_cfg.knee_out_high;
                n_sel.sub = 1'b0;
                n_sel.rnd = 1'b0;
            end
        end else begin
            n_sel.seg  = cst_pkg::SEG_HIGH;
            n_sel.base = cst_pkg::LEVEL_TOP;
            n_sel.sub  = 1'b1;
            n_sel.rnd  = 1'b1;
            n_sel.a    = cst_pkg::LEVEL_TOP - i_cfg.knee_out_high;
            n_sel.b    = cst_pkg::LEVEL_TOP - w_v;
            n_sel.d    = cst_pkg::LEVEL_TOP - i_cfg.knee_in_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sel <= n_sel;
        end
    end

endmodule

### sv/cst_mul.sv
// cst_mul: product stage, forms the dividend of the chosen segment
// depends on cst_pkg

module cst_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cst_pkg::t_sel     i_sel,
    output logic              o_valid,
    input  logic              i_ready,
    output cst_pkg::t_num     o_num
);

    logic                          r_vld;
    cst_pkg::t_num                 r_num;
    cst_pkg::t_num                 n_num;
    logic [cst_pkg::PROD_BITS-1:0] w_prod;
    logic [cst_pkg::PROD_BITS-1:0] w_bias;
    logic [cst_pkg::PIXEL_BITS-1:0] w_dm1;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_num   = r_num;

    assign w_prod = {{cst_pkg::PIXEL_BITS{1'b0}}, i_sel.a} * {{cst_pkg::PIXEL_BITS{1'b0}}, i_sel.b};
    assign w_dm1  = i_sel.d - {{(cst_pkg::PIXEL_BITS-1){1'b0}}, 1'b1};
    // rounding bias turns the floor into a ceiling for the segments that subtract the quotient from their base
    assign w_bias = i_sel.rnd ? {{cst_pkg::PIXEL_BITS{1'b0}}, w_dm1} : '0;

    always_comb begin
        n_num      = '0;
        n_num.seg  = i_sel.seg;
        n_num.last = i_sel.last;
        n_num.base = i_sel.base;
        n_num.sub  = i_sel.sub;
        n_num.p    = w_prod + w_bias;
        n_num.d    = i_sel.d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_num <= n_num;
        end
    end

    a_quotient_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_num.p[cst_pkg::PROD_BITS-1:cst_pkg::PIXEL_BITS] < r_num.d))
        else $error("dividend too large for an 8-bit quotient");

endmodule

### sv/cst_div.sv
// cst_div: pipelined restoring divider, a fixed number of quotient bits per stage
// depends on cst_pkg

module cst_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cst_pkg::t_num     i_num,
    output logic              o_valid,
    input  logic              i_ready,
    output cst_pkg::t_div     o_div
);

    logic [cst_pkg::DIV_STAGES-1:0] r_vld;
    cst_pkg::t_div                  r_div [cst_pkg::DIV_STAGES];
    cst_pkg::t_div                  n_div [cst_pkg::DIV_STAGES];
    cst_pkg::t_div                  w_src [cst_pkg::DIV_STAGES];
    logic [cst_pkg::DIV_STAGES-1:0] w_vin;
    logic [cst_pkg::DIV_STAGES:0]   w_rdy;
    cst_pkg::t_div                  w_entry;

    always_comb begin
        w_entry      = '0;
        w_entry.seg  = i_num.seg;
        w_entry.last = i_num.last;
        w_entry.base = i_num.base;
        w_entry.sub  = i_num.sub;
        w_entry.rem  = i_num.p[cst_pkg::PROD_BITS-1:cst_pkg::PIXEL_BITS];
        w_entry.quo  = i_num.p[cst_pkg::PIXEL_BITS-1:0];
        w_entry.d    = i_num.d;
    end

    always_comb begin
        w_rdy[cst_pkg::DIV_STAGES] = i_ready;
        for (int k = cst_pkg::DIV_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[cst_pkg::DIV_STAGES-1];
    assign o_div   = r_div[cst_pkg::DIV_STAGES-1];

    for (genvar g = 0; g < cst_pkg::DIV_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign w_src[g] = w_entry;
            assign w_vin[g] = i_valid;
        end else begin : g_next
            assign w_src[g] = r_div[g-1];
            assign w_vin[g] = r_vld[g-1];
        end

        always_comb begin
            n_div[g] = w_src[g];
            for (int s = 0; s < cst_pkg::DIV_STEPS_PER_STAGE; s++) begin
                n_div[g] = cst_pkg::div_step(n_div[g]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (w_rdy[g]) begin
                r_vld[g] <= w_vin[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[g] && w_vin[g]) begin
                r_div[g] <= n_div[g];
            end
        end
    end

    for (genvar g = 0; g < cst_pkg::DIV_STAGES; g++) begin : g_check
        a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[g] |-> (r_div[g].rem < r_div[g].d))
            else $error("partial remainder not below divisor");

        a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_vld[g] && !w_rdy[g+1]) |=> (r_vld[g] && $stable(r_div[g])))
            else $error("stalled divider stage changed");
    end

endmodule

### sv/cst_out.sv
// cst_out: output stage, applies the quotient to the segment base and thresholds the level
// depends on cst_pkg

module cst_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cst_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  cst_pkg::t_div     i_div,
    output logic              o_valid,
    input  logic              i_ready,
    output cst_pkg::t_out     o_item
);

    logic                           r_vld;
    cst_pkg::t_out                  r_item;
    cst_pkg::t_out                  n_item;
    logic [cst_pkg::PIXEL_BITS-1:0] w_level;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    // the quotient never carries the level outside the segment's end points
    assign w_level = i_div.sub ? (i_div.base - i_div.quo) : (i_div.base + i_div.quo);

    always_comb begin
        n_item                 = '0;
        n_item.stretched_level = w_level;
        n_item.binary_level    = (w_level <= i_cfg.binary_threshold) ? '0 : i_cfg.max_level;
        n_item.segment_used    = i_div.seg;
        n_item.last_pixel_out  = i_div.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

### sv/contrast_stretch_threshold.sv
// contrast_stretch_threshold: top level, configuration registers and the seven-stage pipeline
// depends on cst_pkg, cst_seg, cst_mul, cst_div, cst_out
//
//   channel   direction   handshake                   payload
//   in        input       i_in_valid / o_in_ready     i_in_item  (cst_pkg::t_in)
//   out       output      o_out_valid / i_out_ready   o_out_item (cst_pkg::t_out)
//   cfg       input       i_cfg_we                    i_cfg_idx, i_cfg_data
//
// one item per clock sustained while the output is not stalled; each item passes through seven registered stages
// (segment select, product, four divider stages at two quotient bits each, output register)
// every stage has its own valid bit and takes a new item while the next stage frees up,
// so an output stall only backs up as far as the first empty stage
// synchronous active-low reset clears all valid bits and loads the register defaults

module contrast_stretch_threshold (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  cst_pkg::t_in                        i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output cst_pkg::t_out                       o_out_item,
    input  logic                                i_cfg_we,
    input  logic [cst_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [cst_pkg::PIXEL_BITS-1:0]      i_cfg_data
);

    cst_pkg::t_cfg r_cfg;
    cst_pkg::t_sel w_sel;
    cst_pkg::t_num w_num;
    cst_pkg::t_div w_div;
    logic          w_sel_vld;
    logic          w_sel_rdy;
    logic          w_num_vld;
    logic          w_num_rdy;
    logic          w_div_vld;
    logic          w_div_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.knee_in_low      <= '0;
            r_cfg.knee_out_low     <= '0;
            r_cfg.knee_in_high     <= cst_pkg::LEVEL_TOP;
            r_cfg.knee_out_high    <= cst_pkg::LEVEL_TOP;
            r_cfg.binary_threshold <= cst_pkg::LEVEL_TOP >> 1;
            r_cfg.max_level        <= cst_pkg::LEVEL_TOP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cst_pkg::CFG_KNEE_IN_LOW:   r_cfg.knee_in_low      <= i_cfg_data;
                cst_pkg::CFG_KNEE_OUT_LOW:  r_cfg.knee_out_low     <= i_cfg_data;
                cst_pkg::CFG_KNEE_IN_HIGH:  r_cfg.knee_in_high     <= i_cfg_data;
                cst_pkg::CFG_KNEE_OUT_HIGH: r_cfg.knee_out_high    <= i_cfg_data;
                cst_pkg::CFG_THRESHOLD:     r_cfg.binary_threshold <= i_cfg_data;
                cst_pkg::CFG_MAX_LEVEL:     r_cfg.max_level        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cst_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (w_sel_vld),
        .i_ready (w_sel_rdy),
        .o_sel   (w_sel)
    );

    cst_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sel_vld),
        .o_ready (w_sel_rdy),
        .i_sel   (w_sel),
        .o_valid (w_num_vld),
        .i_ready (w_num_rdy),
        .o_num   (w_num)
    );

    cst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_num_vld),
        .o_ready (w_num_rdy),
        .i_num   (w_num),
        .o_valid (w_div_vld),
        .i_ready (w_div_rdy),
        .o_div   (w_div)
    );

    cst_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_div_vld),
        .o_ready (w_div_rdy),
        .i_div   (w_div),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    a_empty_output_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with an empty output stage");

endmodule
